// File: hw/rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// RTT tracker package
// Shared constants, table entry layout and controller/datapath signal groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRIES_W   = 5;
  localparam int TIMEOUT_W   = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;
  localparam int S_TDATA_W   = 376;
  localparam int M_TDATA_W   = 168;
  localparam logic signed [20:0] US_PER_S = 21'sd1000000;

  localparam logic [1:0] ST_RECORDED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_MATCHED   = 2'd2;
  localparam logic [1:0] ST_UNMATCHED = 2'd3;

  typedef struct packed {
    logic [19:0] usec;
    logic [31:0] sec;
    logic [31:0] ack;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [63:0] dst_lo;
    logic [63:0] dst_hi;
    logic [63:0] src_lo;
    logic [63:0] src_hi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load_item;
    logic rd;
    logic eval;
    logic finish;
    logic mul;
    logic add;
    logic stat;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic found;
    logic is_ack;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/rtt_div.sv
// ----------------------------------------------------------------------------
// RTT average divider
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtt_div
  import rtt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [63:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [6:0]  count;
  logic [32:0] rem_sh;
  logic [33:0] trial;

  assign rem_sh   = {rem, quo[63]};
  assign trial    = {1'b0, rem_sh} - {2'b00, dvs};
  assign quotient = quo[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
        count <= 7'd64;
      end else if (count != '0) begin
        if (!trial[33]) begin
          rem <= trial[31:0];
        end else begin
          rem <= rem_sh[31:0];
        end
        quo   <= {quo[62:0], !trial[33]};
        count <= count - 7'd1;
        done  <= (count == 7'd1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rtt_datapath.sv
// ----------------------------------------------------------------------------
// RTT tracker datapath
// Pending-segment table, compaction scan, RTT arithmetic and statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtt_datapath
  import rtt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic [S_TDATA_W-1:0]   s_tdata,
  input  wire logic                   s_tuser,
  input  wire logic                   cfg_wr_en,
  input  wire logic [TIMEOUT_W-1:0]   cfg_wr_data,
  output logic [M_TDATA_W-1:0]        m_tdata,
  output logic [1:0]                  m_tuser
);

  entry_t mem [TABLE_DEPTH];
  entry_t item;
  entry_t rdata;
  logic   item_ack;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] kept;
  logic [CNT_W-1:0] total;
  logic   found;
  logic [31:0] hit_sec;
  logic [19:0] hit_us;
  logic signed [53:0] prod;
  logic signed [20:0] udiff;
  logic signed [32:0] sdiff;
  logic signed [53:0] dsum;
  logic signed [32:0] age;
  logic [31:0] rtt;
  logic [31:0] min_rtt;
  logic [31:0] max_rtt;
  logic [63:0] rtt_sum;
  logic [31:0] sample_total;
  logic [31:0] avg;
  logic [TIMEOUT_W-1:0] timeout;
  logic [1:0]  res_status;
  logic   match;
  logic   keep;
  logic   div_done;
  logic [31:0] div_q;

  assign age   = $signed({1'b0, item.sec}) - $signed({1'b0, rdata.sec});
  assign match = rdata.src_hi == item.src_hi && rdata.src_lo == item.src_lo &&
                 rdata.dst_hi == item.dst_hi && rdata.dst_lo == item.dst_lo &&
                 rdata.sport == item.sport && rdata.dport == item.dport &&
                 rdata.ack == item.ack;
  assign keep  = item_ack ? !(match && !found)
                          : !(!age[32] && (age[31:0] > {16'd0, timeout}));
  assign sdiff = $signed({1'b0, item.sec}) - $signed({1'b0, hit_sec});
  assign dsum  = prod + 54'(udiff);

  assign sts.more     = idx < total;
  assign sts.found    = found;
  assign sts.is_ack   = item_ack;
  assign sts.div_done = div_done;

  rtt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rtt_sum),
    .divisor  (sample_total),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[idx[IDX_W-1:0]];
    end
    if (cmd.eval && keep) begin
      mem[kept[IDX_W-1:0]] <= rdata;
    end else if (cmd.finish && !item_ack && kept < CNT_W'(TABLE_DEPTH)) begin
      mem[kept[IDX_W-1:0]] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      kept         <= '0;
      total        <= '0;
      found        <= 1'b0;
      min_rtt      <= '0;
      max_rtt      <= '0;
      rtt_sum      <= '0;
      sample_total <= '0;
      avg          <= '0;
      timeout      <= TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (cmd.load_item) begin
        item     <= entry_t'(s_tdata[ENTRY_W-1:0]);
        item_ack <= s_tuser;
        idx      <= '0;
        kept     <= '0;
        found    <= 1'b0;
        rtt      <= '0;
      end
      if (cmd.eval) begin
        idx <= idx + 1'b1;
        if (keep) begin
          kept <= kept + 1'b1;
        end
        if (item_ack && match && !found) begin
          found   <= 1'b1;
          hit_sec <= rdata.sec;
          hit_us  <= rdata.usec;
        end
      end
      if (cmd.finish) begin
        if (item_ack) begin
          total      <= kept;
          res_status <= found ? ST_MATCHED : ST_UNMATCHED;
        end else if (kept < CNT_W'(TABLE_DEPTH)) begin
          total      <= kept + 1'b1;
          res_status <= ST_RECORDED;
        end else begin
          total      <= kept;
          res_status <= ST_FULL;
        end
      end
      if (cmd.mul) begin
        prod  <= 54'(sdiff) * 54'(US_PER_S);
        udiff <= $signed({1'b0, item.usec}) - $signed({1'b0, hit_us});
      end
      if (cmd.add) begin
        if (dsum[53]) begin
          rtt <= '0;
        end else if (|dsum[52:32]) begin
          rtt <= '1;
        end else begin
          rtt <= dsum[31:0];
        end
      end
      if (cmd.stat) begin
        if (min_rtt == '0 || rtt < min_rtt) begin
          min_rtt <= rtt;
        end
        if (rtt > max_rtt) begin
          max_rtt <= rtt;
        end
        if (sample_total != '1) begin
          rtt_sum      <= rtt_sum + 64'(rtt);
          sample_total <= sample_total + 32'd1;
        end
      end
      if (div_done) begin
        avg <= div_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {3'b000, ENTRIES_W'(total), sample_total, avg, max_rtt, min_rtt, rtt};
      m_tuser <= res_status;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(TABLE_DEPTH))
    else $error("table count beyond depth");

  a_kept_le_idx: assert property (@(posedge clk) disable iff (rst)
    kept <= idx)
    else $error("compaction write index passed read index");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> sample_total >= $past(sample_total))
    else $error("sample count went backwards");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    min_rtt != '0 |-> min_rtt <= max_rtt)
    else $error("min above max");

endmodule

`default_nettype wire

// File: hw/rtl/rtt_ctrl.sv
// ----------------------------------------------------------------------------
// RTT tracker controller
// Sequences the table scan, RTT computation, division and result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtt_ctrl
  import rtt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  wire logic m_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    IDLE, READ, EVAL, FINISH, MUL, ADD, STAT, DIV, DIV_WAIT, DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load_item = (state == IDLE) && s_tvalid;
    cmd.rd        = (state == READ) && sts.more;
    cmd.eval      = (state == EVAL);
    cmd.finish    = (state == FINISH);
    cmd.mul       = (state == MUL);
    cmd.add       = (state == ADD);
    cmd.stat      = (state == STAT);
    cmd.div_start = (state == DIV);
    cmd.out_load  = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= READ;
          end
        end
        READ: begin
          state <= sts.more ? EVAL : FINISH;
        end
        EVAL: begin
          state <= READ;
        end
        FINISH: begin
          state <= (sts.is_ack && sts.found) ? MUL : DONE;
        end
        MUL: begin
          state <= ADD;
        end
        ADD: begin
          state <= STAT;
        end
        STAT: begin
          state <= DIV;
        end
        DIV: begin
          state <= DIV_WAIT;
        end
        DIV_WAIT: begin
          if (sts.div_done) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tcp_flow_rtt_tracker.sv
// Sequence: a send scans the n entries held before it, each with a registered
// table read and a compaction write, then records itself.
// An ack scans its k entries the same way; with a match it adds the RTT
// arithmetic (multiply, add, statistics) and the bit-serial divider.
// Throughput: one transfer in at a time; the next is taken on return to idle.
// Reset (synchronous, rst high): table empty, statistics zero, timeout 10 s.
// ----------------------------------------------------------------------------
// TCP flow RTT tracker
// Records outgoing segments and measures round trip time on matching acks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcp_flow_rtt_tracker
  import rtt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // src_ip_high, src_ip_low, dst_ip_high, dst_ip_low, source port,
  // destination port, ack_number, ts_seconds, ts_microseconds, zero pad
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // req_type
  input  wire logic                 s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // rtt_us, rtt_min_us, rtt_max_us, rtt_avg_us, samples_taken,
  // entries_in_use, zero pad
  output logic [M_TDATA_W-1:0]      m_tdata,
  // status
  output logic [1:0]                m_tuser,
  input  wire logic                 cfg_wr_en,
  input  wire logic [TIMEOUT_W-1:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

// File: tb/tcp_flow_rtt_tracker_tb.sv
// ----------------------------------------------------------------------------
// TCP flow RTT tracker testbench
// Drives send and ack transfers with random gaps and back-pressure, predicts
// the status and RTT statistics of every result and compares each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_flow_rtt_tracker_tb;
  import rtt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  typedef struct {
    bit          is_ack;
    bit [63:0]   src_hi, src_lo, dst_hi, dst_lo;
    bit [15:0]   sport, dport;
    bit [31:0]   ack, sec;
    bit [19:0]   usec;
  } seg_t;

  typedef struct {
    bit [1:0]  status;
    bit [31:0] rtt, rtt_min, rtt_max, rtt_avg, samples;
    bit [4:0]  entries;
  } rtt_report_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_wr_en = 0;
  logic [TIMEOUT_W-1:0] cfg_wr_data = '0;

  always #1 clk = ~clk;

  tcp_flow_rtt_tracker dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  seg_t        pending[$];
  bit [15:0]   age_limit = TIMEOUT_RESET;
  bit [31:0]   min_us, max_us, sample_cnt;
  bit [63:0]   sum_us;
  rtt_report_t expected_reports[$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_off = 0;
  bit  stall_sink = 0;
  seg_t flows[8];

  function automatic bit same_flow(seg_t a, seg_t b);
    return a.src_hi == b.src_hi && a.src_lo == b.src_lo && a.dst_hi == b.dst_hi &&
           a.dst_lo == b.dst_lo && a.sport == b.sport &&
           a.dport == b.dport && a.ack == b.ack;
  endfunction

  function automatic rtt_report_t track_rtt(seg_t s);
    rtt_report_t r;
    longint signed age, d;
    int hit;
    seg_t kept[$];
    r = '{default: 0};
    if (!s.is_ack) begin
      foreach (pending[i]) begin
        age = longint'(s.sec) - longint'(pending[i].sec);
        if (age <= longint'(age_limit)) kept.push_back(pending[i]);
      end
      pending = kept;
      if (pending.size() < TABLE_DEPTH) begin
        pending.push_back(s);
        r.status = ST_RECORDED;
      end else r.status = ST_FULL;
    end else begin
      hit = -1;
      foreach (pending[i])
        if (hit < 0 && same_flow(pending[i], s)) hit = i;
      if (hit >= 0) begin
        d = (longint'(s.sec) * 1000000 + longint'(s.usec)) -
            (longint'(pending[hit].sec) * 1000000 + longint'(pending[hit].usec));
        if (d < 0) r.rtt = 0;
        else if (d > 64'hFFFF_FFFF) r.rtt = 32'hFFFF_FFFF;
        else r.rtt = d[31:0];
        pending.delete(hit);
        if (min_us == 0 || r.rtt < min_us) min_us = r.rtt;
        if (r.rtt > max_us) max_us = r.rtt;
        if (sample_cnt != 32'hFFFF_FFFF) begin
          sum_us += r.rtt;
          sample_cnt++;
        end
        r.status = ST_MATCHED;
      end else r.status = ST_UNMATCHED;
    end
    r.rtt_min = min_us;
    r.rtt_max = max_us;
    r.rtt_avg = sample_cnt ? 32'(sum_us / sample_cnt) : 32'd0;
    r.samples = sample_cnt;
    r.entries = 5'(pending.size());
    return r;
  endfunction

  task automatic send_segment(seg_t s);
    expected_reports.push_back(track_rtt(s));
    s_tvalid <= 1;
    s_tuser  <= s.is_ack;
    s_tdata  <= {4'd0, s.usec, s.sec, s.ack, s.dport, s.sport,
                 s.dst_lo, s.dst_hi, s.src_lo, s.src_hi};
    do @(posedge clk); while (!s_tready);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(bit [15:0] v);
    wait_drained();
    cfg_wr_en   <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    age_limit = v;
  endtask

  function automatic seg_t random_seg(bit is_ack);
    seg_t s;
    s.is_ack = is_ack;
    s.src_hi = {$urandom, $urandom}; s.src_lo = {$urandom, $urandom};
    s.dst_hi = {$urandom, $urandom}; s.dst_lo = {$urandom, $urandom};
    s.sport = 16'($urandom); s.dport = 16'($urandom);
    s.ack = $urandom; s.sec = $urandom;
    s.usec = $urandom_range(0, 7) == 0 ? 20'($urandom) : 20'($urandom_range(0, 999999));
    return s;
  endfunction

  task automatic test_directed();
    seg_t a, b;
    a = random_seg(0);
    a.src_hi = '1; a.src_lo = '1; a.dst_hi = '1; a.dst_lo = '1;
    a.sport = '1; a.dport = '1; a.ack = '1; a.sec = 100; a.usec = 20'hFFFFF;
    send_segment(a);
    b = a; b.is_ack = 1; b.sec = 101; b.usec = 0;
    send_segment(b);                        // match, rtt from overlong usec
    send_segment(b);                        // unmatched now
    a = '{default: 0}; send_segment(a);     // all zero
    b = a; b.is_ack = 1; send_segment(b);   // zero sample keeps min unset
    a.sec = 50; send_segment(a);
    b = a; b.is_ack = 1; b.sec = 40; send_segment(b);   // negative rtt
    a.sec = 0; send_segment(a);
    b = a; b.is_ack = 1; b.sec = '1; send_segment(b);   // saturating rtt
    a.sec = 1000; send_segment(a);
    a.sec = 5; a.ack = 7; send_segment(a);  // stamped before: negative age, kept
    a.sec = 1011; a.ack = 8; send_segment(a);   // evicts the 1000 and the 5 entries
    b = a; b.is_ack = 1; b.ack = 7; b.usec = 3; send_segment(b);
    for (int i = 0; i < 18; i++) begin      // fill past the table
      a = random_seg(0); a.sec = 2000; send_segment(a);
    end
  endtask

  task automatic test_random(int count);
    seg_t s;
    int k;
    bit [31:0] now;
    now = $urandom;
    for (int i = 0; i < 8; i++) flows[i] = random_seg(0);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 7);
      now += $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          s = flows[k]; s.is_ack = 0; s.ack = $urandom_range(0, 3);
          s.sec = now; s.usec = 20'($urandom_range(0, 999999));
        end
        4, 5, 6, 7: begin
          s = flows[k]; s.is_ack = 1; s.ack = $urandom_range(0, 3);
          s.sec = now + $urandom_range(0, 1); s.usec = 20'($urandom_range(0, 999999));
        end
        default: s = random_seg(1'($urandom_range(0, 1)));
      endcase
      send_segment(s);
    end
  endtask

  task automatic test_backpressure();
    stall_sink = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        stall_sink = 0;
      end
      test_random(30);
    join
  endtask

  // sink with random stalls
  always @(posedge clk) begin
    if (rst || stall_sink) m_tready <= 0;
    else if ($urandom_range(0, 3) == 0) m_tready <= 0;
    else m_tready <= 1;
  end

  always @(posedge clk) begin
    rtt_report_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = expected_reports.pop_front();
        if (m_tuser != e.status) begin
          $error("status exp %0d got %0d", e.status, m_tuser); errors++;
        end
        if (m_tdata[31:0] != e.rtt) begin
          $error("rtt_us exp %0d got %0d", e.rtt, m_tdata[31:0]); errors++;
        end
        if (m_tdata[63:32] != e.rtt_min) begin
          $error("rtt_min_us exp %0d got %0d", e.rtt_min, m_tdata[63:32]); errors++;
        end
        if (m_tdata[95:64] != e.rtt_max) begin
          $error("rtt_max_us exp %0d got %0d", e.rtt_max, m_tdata[95:64]); errors++;
        end
        if (m_tdata[127:96] != e.rtt_avg) begin
          $error("rtt_avg_us exp %0d got %0d", e.rtt_avg, m_tdata[127:96]); errors++;
        end
        if (m_tdata[159:128] != e.samples) begin
          $error("samples_taken exp %0d got %0d", e.samples, m_tdata[159:128]); errors++;
        end
        if (m_tdata[164:160] != e.entries) begin
          $error("entries_in_use exp %0d got %0d", e.entries, m_tdata[164:160]); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || expected_reports.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** tcp_flow_rtt_tracker: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    write_timeout(16'd0);
    test_random(200);
    write_timeout(16'hFFFF);
    test_random(200);
    write_timeout(16'd3);
    test_backpressure();
    wait_drained();
    test_random(200);
    write_timeout(16'd10);
    test_random(200);
    wait_drained();
    if (errors == 0) $display("** tcp_flow_rtt_tracker: PASSED **");
    else $display("** tcp_flow_rtt_tracker: FAILED **");
    $finish;
  end
endmodule
